[sv/assert_macros.svh]
// Assertion macros shared by the dispatcher modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge outside reset.
`define CFSD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define CFSD_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[sv/cfsd_pkg.sv]
// Shared constants, command and status types and helpers of the dispatcher.
package cfsd_pkg;

  localparam int NUM_SERVERS_DEF = 16;
  localparam int SRV_MAX         = 16;
  localparam int SRV_W           = 4;
  localparam int TIME_W          = 31;
  localparam int BUSY_W          = 32;
  localparam int COUNT_W         = 32;
  localparam int CFG_W           = 5;

  localparam logic [CFG_W-1:0] ACTIVE_RST = 5'd16;

  localparam logic KIND_ASSIGN  = 1'b0;
  localparam logic KIND_BUSIEST = 1'b1;

  typedef struct packed {
    logic capture;
    logic pick;
    logic match;
    logic load_assign;
    logic load_report;
    logic clear;
  } cfsd_cmd_t;

  typedef struct packed {
    logic final_req;
    logic out_free;
    logic mask_empty;
    logic report_last;
  } cfsd_sts_t;

  function automatic logic [SRV_W-1:0] first_set(input logic [SRV_MAX-1:0] m);
    logic [SRV_W-1:0] r;
    r = '0;
    for (int i = SRV_MAX - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = SRV_W'(i);
      end
    end
    return r;
  endfunction

endpackage

[sv/cfsd_req_if.sv]
// Request channel: arrival, service time and final mark.
interface cfsd_req_if;
  logic                        valid;
  logic                        ready;
  logic [cfsd_pkg::TIME_W-1:0] arrival_time;
  logic [cfsd_pkg::TIME_W-1:0] service_time;
  logic                        final_request;

  modport source (output valid, arrival_time, service_time, final_request, input ready);
  modport sink   (input valid, arrival_time, service_time, final_request, output ready);
endinterface

[sv/cfsd_res_if.sv]
// Result channel: assignment and busiest-server beats.
interface cfsd_res_if;
  logic                         valid;
  logic                         ready;
  logic                         result_kind;
  logic [cfsd_pkg::SRV_W-1:0]   server_id;
  logic                         dropped;
  logic [cfsd_pkg::COUNT_W-1:0] handled_count;
  logic                         last_of_run;

  modport source (output valid, result_kind, server_id, dropped, handled_count,
                  last_of_run, input ready);
  modport sink   (input valid, result_kind, server_id, dropped, handled_count,
                  last_of_run, output ready);
endinterface

[sv/cfsd_cfg_if.sv]
// Configuration write channel for the active server count.
interface cfsd_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [cfsd_pkg::CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[sv/cyclic_free_server_dispatcher.sv]
// Top level of the round-robin free-server dispatcher.
// Requests are taken only in the idle state; each passes the pick state, the match
// state (busiest scan, final requests only) and the emit state; a final request then
// emits each busiest-server beat in turn. The single output register can stall loads.
// Reset: synchronous, clears all busy times, counts and the start position, and sets
// the active server count to 16; no clearing pass follows.
module cyclic_free_server_dispatcher #(
  parameter int NUM_SERVERS = cfsd_pkg::NUM_SERVERS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  cfsd_req_if.sink   req,
  cfsd_res_if.source res,
  cfsd_cfg_if.sink   cfg
);

  cfsd_pkg::cfsd_cmd_t cmd;
  cfsd_pkg::cfsd_sts_t sts;

  cfsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cfsd_dp #(
    .NUM_SERVERS (NUM_SERVERS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res),
    .cfg (cfg),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

[sv/cfsd_ctrl.sv]
// Sequencing state machine of the dispatcher.
`include "assert_macros.svh"

module cfsd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  cfsd_pkg::cfsd_sts_t sts,
  output cfsd_pkg::cfsd_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PICK   = 5'b00010,
    S_MATCH  = 5'b00100,
    S_EMIT   = 5'b01000,
    S_REPORT = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
        if (req_valid) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        cmd.pick   = 1'b1;
        state_next = sts.final_req ? S_MATCH : S_EMIT;
      end
      S_MATCH: begin
        cmd.match  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_assign = 1'b1;
          if (sts.final_req && !sts.mask_empty) begin
            state_next = S_REPORT;
          end else begin
            cmd.clear  = sts.final_req;
            state_next = S_IDLE;
          end
        end
      end
      S_REPORT: begin
        if (sts.out_free) begin
          cmd.load_report = 1'b1;
          if (sts.report_last) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `CFSD_ASSERT_NEXT(a_capture_then_pick, clk, rst, cmd.capture, cmd.pick, "pick must follow capture")
  `CFSD_ASSERT(a_load_needs_space, clk, rst, !(cmd.load_assign || cmd.load_report) || sts.out_free, "output loaded while occupied")

endmodule

[sv/cfsd_dp.sv]
// Server state, free compare, rotating pick, busiest scan and output register.
`include "assert_macros.svh"

module cfsd_dp #(
  parameter int NUM_SERVERS = cfsd_pkg::NUM_SERVERS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  cfsd_req_if.sink            req,
  cfsd_res_if.source          res,
  cfsd_cfg_if.sink            cfg,
  input  cfsd_pkg::cfsd_cmd_t cmd,
  output cfsd_pkg::cfsd_sts_t sts
);

  localparam int IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int CNT_W = $clog2(NUM_SERVERS + 1);
  localparam int FULL  = cfsd_pkg::SRV_MAX;
  localparam int SRV_W = cfsd_pkg::SRV_W;
  localparam int CFG_W = cfsd_pkg::CFG_W;
  localparam int BW    = cfsd_pkg::BUSY_W;
  localparam int CW    = cfsd_pkg::COUNT_W;
  localparam int TW    = cfsd_pkg::TIME_W;

  logic [CFG_W-1:0]       cfg_active;
  logic [BW-1:0]          busy    [NUM_SERVERS];
  logic [CW-1:0]          handled [NUM_SERVERS];
  logic [CW-1:0]          highest;
  logic [IDX_W-1:0]       start_pos;

  logic [TW-1:0]          arrival_q;
  logic [TW-1:0]          service_q;
  logic                   final_q;
  logic [NUM_SERVERS-1:0] free_q;
  logic [CNT_W-1:0]       n_q;
  logic [IDX_W-1:0]       pos_q;
  logic                   asg_found;
  logic [IDX_W-1:0]       asg_srv;
  logic [CW-1:0]          asg_count;
  logic [NUM_SERVERS-1:0] mask_q;

  logic                   res_valid;
  logic                   res_kind;
  logic [SRV_W-1:0]       res_id;
  logic                   res_drop;
  logic [CW-1:0]          res_count;
  logic                   res_last;

  logic [CFG_W-1:0]       n_clip;
  logic [CNT_W-1:0]       n_next;
  logic [IDX_W-1:0]       pos_next;
  logic [NUM_SERVERS-1:0] free_next;
  logic [NUM_SERVERS-1:0] ge_mask;
  logic [NUM_SERVERS-1:0] free_hi;
  logic                   found;
  logic [IDX_W-1:0]       sel;
  logic [CW-1:0]          cnt_new;
  logic [CNT_W-1:0]       pos_inc;
  logic [NUM_SERVERS-1:0] match_next;
  logic [NUM_SERVERS-1:0] mask_rest;
  logic [IDX_W-1:0]       rep_idx;

  assign cfg.ready = 1'b1;

  // Clamp the register into 1..NUM_SERVERS.
  always_comb begin
    if (cfg_active == '0) begin
      n_clip = CFG_W'(1);
    end else if (cfg_active > CFG_W'(NUM_SERVERS)) begin
      n_clip = CFG_W'(NUM_SERVERS);
    end else begin
      n_clip = cfg_active;
    end
  end

  assign n_next   = CNT_W'(n_clip);
  assign pos_next = (CNT_W'(start_pos) >= n_next) ? '0 : start_pos;

  always_comb begin
    for (int i = 0; i < NUM_SERVERS; i++) begin
      free_next[i]  = (CNT_W'(i) < n_next) && (busy[i] <= BW'(req.arrival_time));
      ge_mask[i]    = (IDX_W'(i) >= pos_q);
      match_next[i] = (CNT_W'(i) < n_q) && (handled[i] == highest);
    end
  end

  assign free_hi   = free_q & ge_mask;
  assign found     = |free_q;
  assign sel       = (|free_hi) ? IDX_W'(cfsd_pkg::first_set(FULL'(free_hi)))
                                : IDX_W'(cfsd_pkg::first_set(FULL'(free_q)));
  assign cnt_new   = (handled[sel] == '1) ? handled[sel] : handled[sel] + CW'(1);
  assign pos_inc   = CNT_W'(pos_q) + CNT_W'(1);
  assign mask_rest = mask_q & (mask_q - NUM_SERVERS'(1));
  assign rep_idx   = IDX_W'(cfsd_pkg::first_set(FULL'(mask_q)));

  // Control and server state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_active <= cfsd_pkg::ACTIVE_RST;
      highest    <= '0;
      start_pos  <= '0;
      res_valid  <= 1'b0;
      for (int i = 0; i < NUM_SERVERS; i++) begin
        busy[i]    <= '0;
        handled[i] <= '0;
      end
    end else begin
      if (cfg.valid && cfg.ready) begin
        cfg_active <= cfg.data;
      end
      if (cmd.pick) begin
        start_pos <= (pos_inc >= n_q) ? '0 : IDX_W'(pos_inc);
        if (found) begin
          handled[sel] <= cnt_new;
          busy[sel]    <= BW'(arrival_q) + BW'(service_q);
          if (cnt_new > highest) begin
            highest <= cnt_new;
          end
        end
      end
      if (cmd.clear) begin
        highest   <= '0;
        start_pos <= '0;
        for (int i = 0; i < NUM_SERVERS; i++) begin
          busy[i]    <= '0;
          handled[i] <= '0;
        end
      end
      if (cmd.load_assign || cmd.load_report) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Working and output payload.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      arrival_q <= req.arrival_time;
      service_q <= req.service_time;
      final_q   <= req.final_request;
      free_q    <= free_next;
      n_q       <= n_next;
      pos_q     <= pos_next;
    end
    if (cmd.pick) begin
      asg_found <= found;
      asg_srv   <= found ? sel : '0;
      asg_count <= found ? cnt_new : '0;
    end
    if (cmd.match) begin
      mask_q <= match_next;
    end else if (cmd.load_report) begin
      mask_q <= mask_rest;
    end
    if (cmd.load_assign) begin
      res_kind  <= cfsd_pkg::KIND_ASSIGN;
      res_id    <= SRV_W'(asg_srv);
      res_drop  <= !asg_found;
      res_count <= asg_count;
      res_last  <= !final_q || (mask_q == '0);
    end else if (cmd.load_report) begin
      res_kind  <= cfsd_pkg::KIND_BUSIEST;
      res_id    <= SRV_W'(rep_idx);
      res_drop  <= 1'b0;
      res_count <= highest;
      res_last  <= (mask_rest == '0);
    end
  end

  assign res.valid         = res_valid;
  assign res.result_kind   = res_kind;
  assign res.server_id     = res_id;
  assign res.dropped       = res_drop;
  assign res.handled_count = res_count;
  assign res.last_of_run   = res_last;

  assign sts.final_req   = final_q;
  assign sts.out_free    = !res_valid || res.ready;
  assign sts.mask_empty  = (mask_q == '0);
  assign sts.report_last = (mask_rest == '0);

  `CFSD_ASSERT_NEXT(a_start_in_range, clk, rst, cmd.pick, CNT_W'(start_pos) < n_q, "start position beyond active count")
  `CFSD_ASSERT_NEXT(a_clear_highest, clk, rst, cmd.clear, highest == '0, "highest count survived clear")

endmodule
